// ===== hdl/mqts_pkg.sv =====
package mqts_pkg;

  localparam int DEPTH       = 1024;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int QUEUE_DEPTH = 2;

  // opcodes
  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_FRONT = 3'd2;
  localparam logic [2:0] OP_SIZE  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_MIN   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
  } out_item_t;

  // decoded operation, all zero for an unused opcode
  typedef struct packed {
    logic enq;
    logic deq;
    logic peek;
    logic size;
    logic clr;
    logic mini;
  } op_dec_t;

  typedef struct packed {
    op_dec_t            op;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// ===== hdl/mqts_ram.sv =====
module mqts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mqts_front.sv =====
module mqts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mqts_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output mqts_pkg::cmd_t     cmd
);
  import mqts_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  op_dec_t           dec;
  cmd_t              new_cmd;

  // opcode decode
  always_comb begin
    dec = '0;
    case (in_data.opcode)
      OP_ENQ:   dec.enq  = 1'b1;
      OP_DEQ:   dec.deq  = 1'b1;
      OP_FRONT: dec.peek = 1'b1;
      OP_SIZE:  dec.size = 1'b1;
      OP_CLEAR: dec.clr  = 1'b1;
      OP_MIN:   dec.mini = 1'b1;
      default:  dec = '0;
    endcase
    new_cmd.op    = dec;
    new_cmd.value = in_data.value;
  end

  assign in_stall  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== hdl/mqts_back.sv =====
module mqts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  mqts_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output mqts_pkg::out_item_t out_data
);
  import mqts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POUR = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] mn;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (b < a) ? b : a;
  endfunction

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic [CNT_W-1:0]   bc_r, bc_nxt;
  logic               pv_r, pv_nxt;
  logic signed [31:0] pmin_r, pmin_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [CNT_W-1:0]   total, fc_m1, bc_m1;
  logic               need_pour, out_free, pour_issue;
  logic signed [31:0] pour_min;

  logic              f_we, f_re, b_we, b_re;
  logic [ADDR_W-1:0] f_waddr, f_raddr, b_waddr, b_raddr;
  entry_t            f_wdata, f_rdata, b_wdata, b_rdata;

  mqts_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_front_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  mqts_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_back_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign total      = fc_r + bc_r;
  assign fc_m1      = fc_r - CNT_W'(1);
  assign bc_m1      = bc_r - CNT_W'(1);
  assign need_pour  = (fc_r == '0) && (bc_r != '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign pour_issue = (state_r == S_POUR) && (bc_r != '0);
  assign pour_min   = (fc_r == '0) ? b_rdata.val : smin(b_rdata.val, pmin_r);

  // both tops are read from the same counters every time
  assign f_raddr = fc_m1[ADDR_W-1:0];
  assign b_raddr = bc_m1[ADDR_W-1:0];
  assign f_re    = (state_r == S_IDLE) && cmd_valid && !need_pour;
  assign b_re    = f_re || pour_issue;

  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    bc_nxt        = bc_r;
    pv_nxt        = 1'b0;
    pmin_nxt      = pmin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    f_we          = 1'b0;
    f_waddr       = fc_r[ADDR_W-1:0];
    f_wdata.val   = b_rdata.val;
    f_wdata.mn    = pour_min;
    b_we          = 1'b0;
    b_waddr       = bc_r[ADDR_W-1:0];
    b_wdata.val   = cmd.value;
    b_wdata.mn    = (bc_r == '0) ? cmd.value : smin(cmd.value, b_rdata.mn);

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = need_pour ? S_POUR : S_EXEC;
        end
      end
      S_POUR: begin
        // read of back top and write of front top overlap: pv_r marks the read data that is written next
        if (pour_issue) begin
          bc_nxt = bc_m1;
        end
        pv_nxt = pour_issue;
        if (pv_r) begin
          f_we     = 1'b1;
          fc_nxt   = fc_r + CNT_W'(1);
          pmin_nxt = pour_min;
        end
        if (bc_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_pop       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, data: '0};
          state_nxt     = S_IDLE;
          if (cmd.op.enq) begin
            if (total >= CNT_W'(DEPTH)) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              b_we   = 1'b1;
              bc_nxt = bc_r + CNT_W'(1);
            end
          end else if (cmd.op.deq || cmd.op.peek) begin
            // front empty after the pour means the whole queue is empty
            if (fc_r == '0) begin
              out_data_nxt.status = ST_EMPTY;
            end else begin
              out_data_nxt = '{status: ST_DATA, data: f_rdata.val};
              if (cmd.op.deq) begin
                fc_nxt = fc_m1;
              end
            end
          end else if (cmd.op.size) begin
            out_data_nxt = '{status: ST_DATA, data: $signed(32'(total))};
          end else if (cmd.op.clr) begin
            fc_nxt = '0;
            bc_nxt = '0;
          end else if (cmd.op.mini) begin
            if (total == '0) begin
              out_data_nxt.status = ST_EMPTY;
            end else if (fc_r == '0) begin
              out_data_nxt = '{status: ST_DATA, data: b_rdata.mn};
            end else if (bc_r == '0) begin
              out_data_nxt = '{status: ST_DATA, data: f_rdata.mn};
            end else begin
              out_data_nxt = '{status: ST_DATA, data: smin(f_rdata.mn, b_rdata.mn)};
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= '0;
      bc_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      bc_r        <= bc_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pmin_r     <= pmin_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/min_queue_two_stacks.sv =====
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall    in_item_t  {opcode, value}
// out_      output     out_valid / out_stall  out_item_t {status, data}
//
// one result transaction per input transaction, in order
// each transaction starts the stack ram reads in S_IDLE and executes in S_EXEC on the registered data
// a transaction that finds the front stack empty and the back stack not empty first pours
//   the back stack into the front stack, one ram read and write per entry
// synchronous active-low reset clears counts and control; the rams are not cleared
// a two-entry command queue lets input be taken while a result waits on out_stall
module min_queue_two_stacks (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mqts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mqts_pkg::out_item_t out_data
);
  import mqts_pkg::*;

  // decoded commands between the front end and the stack engine
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front end: accept the transaction, decode the opcode, queue it
  mqts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // back end: pour, read tops, execute, register the result
  mqts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a command is only retired when one is waiting
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command retired from an empty queue");

  // every retired command shows up as a result in the next cycle
  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> out_valid)
    else $error("retired command produced no result");

  // data field is zero unless the status carries data
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_DATA)) |-> (out_data.data == '0))
    else $error("nonzero data without data status");

endmodule
